// ----- rtl/fpst_pkg.sv -----
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared types, opcode constants and helper functions for the five-stage
// pipeline stage timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpst_pkg;

	localparam int REG_COUNT  = 32;
	localparam int REG_AW     = $clog2(REG_COUNT);
	localparam int CYCLE_BITS = 16;

	typedef logic [CYCLE_BITS-1:0] cycle_t;
	typedef logic [CYCLE_BITS:0]   cycle_wide_t;
	typedef logic [REG_AW-1:0]     reg_idx_t;

	localparam cycle_t CYCLE_MAX = '1;

	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;

	typedef enum logic [2:0] {
		FMT_R       = 3'd0,
		FMT_LOAD    = 3'd1,
		FMT_I       = 3'd2,
		FMT_STORE   = 3'd3,
		FMT_U       = 3'd4,
		FMT_BRANCH  = 3'd5,
		FMT_JAL     = 3'd6,
		FMT_UNKNOWN = 3'd7
	} fmt_t;

	// One scoreboard write: register index and its new ready cycle.
	typedef struct packed {
		logic     en;
		reg_idx_t addr;
		cycle_t   data;
	} sb_wr_t;

	function automatic fmt_t classify(input logic [6:0] opcode);
		fmt_t f;
		case (opcode)
			OPC_OP:     f = FMT_R;
			OPC_LOAD:   f = FMT_LOAD;
			OPC_OP_IMM: f = FMT_I;
			OPC_JALR:   f = FMT_I;
			OPC_SYSTEM: f = FMT_I;
			OPC_STORE:  f = FMT_STORE;
			OPC_LUI:    f = FMT_U;
			OPC_AUIPC:  f = FMT_U;
			OPC_BRANCH: f = FMT_BRANCH;
			OPC_JAL:    f = FMT_JAL;
			default:    f = FMT_UNKNOWN;
		endcase
		return f;
	endfunction

	// Saturates a one-bit-wider sum to the cycle range.
	function automatic cycle_t sat(input cycle_wide_t v);
		return v[CYCLE_BITS] ? CYCLE_MAX : v[CYCLE_BITS-1:0];
	endfunction

	function automatic cycle_t cmax(input cycle_t a, input cycle_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- rtl/forwarding_pipeline_stage_timer_unit.sv -----
// ----------------------------------------------------------------------------
// forwarding_pipeline_stage_timer_unit
// Takes one RV32 instruction word per item, in program order, and returns the
// IF, ID, EX, MEM and WB cycle numbers it would see in an in-order five-stage
// pipeline with full forwarding, plus the stall cycles before ID and EX, the
// decoded format and a sticky saturation flag. The block accepts one item
// every cycle while in_stall is low. The accepting edge registers the
// instruction word and the scoreboard memory read, and the edge on which the
// item advances registers the timing update into the output register. A
// result held by out_stall leaves room for one more item behind it, so the
// input stalls only while both the output register and that item are
// waiting. The 32 ready cycles live in a synchronous memory whose entries
// read as zero after reset through per-entry valid bits, so no clearing pass
// is needed and items are accepted right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module forwarding_pipeline_stage_timer_unit import fpst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output cycle_t      fetch_cycle,
	output cycle_t      decode_cycle,
	output cycle_t      execute_cycle,
	output cycle_t      memory_cycle,
	output cycle_t      writeback_cycle,
	output cycle_t      decode_wait,
	output cycle_t      execute_wait,
	output logic [2:0]  format_class,
	output logic        overflow
);

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        accept;
	logic        advance;
	logic        out_valid_q;

	cycle_t next_fetch_q;
	cycle_t last_exec_q;
	logic   ovf_q;

	cycle_t r1;
	cycle_t r2;
	sb_wr_t sb_wr;

	fmt_t     fmt;
	reg_idx_t rd;

	cycle_wide_t f1_w, d_w, d1_w, t_rr_w, t_r1_w, m_w, w_w;
	cycle_t      f1, d, d1, rmax, e, m, w;
	logic        ov_t;
	logic        ovf_next;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= instr_word;
		end
	end

	fpst_scoreboard u_sb (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rs1    (instr_word[19:15]),
		.rs2    (instr_word[24:20]),
		.wr     (sb_wr),
		.r1     (r1),
		.r2     (r2)
	);

	assign fmt = classify(word_s1[6:0]);
	assign rd  = word_s1[11:7];

	always_comb begin
		f1_w   = {1'b0, next_fetch_q} + cycle_wide_t'(1);
		f1     = sat(f1_w);
		d_w    = (f1_w > {1'b0, last_exec_q}) ? f1_w : {1'b0, last_exec_q};
		d      = sat(d_w);
		d1_w   = {1'b0, d} + cycle_wide_t'(1);
		d1     = sat(d1_w);
		rmax   = cmax(r1, r2);
		t_rr_w = {1'b0, rmax} + cycle_wide_t'(1);
		t_r1_w = {1'b0, r1} + cycle_wide_t'(1);
		ov_t   = 1'b0;
		case (fmt)
			FMT_R, FMT_BRANCH: begin
				e    = cmax(d1, sat(t_rr_w));
				ov_t = t_rr_w[CYCLE_BITS];
			end
			FMT_I: begin
				e    = cmax(d1, sat(t_r1_w));
				ov_t = t_r1_w[CYCLE_BITS];
			end
			FMT_LOAD:  e = cmax(d1, r1);
			FMT_STORE: e = cmax(d1, rmax);
			default:   e = d1;
		endcase
		m_w = {1'b0, e} + cycle_wide_t'(1);
		w_w = {1'b0, e} + cycle_wide_t'(2);
		m   = sat(m_w);
		w   = sat(w_w);
		ovf_next = ovf_q | f1_w[CYCLE_BITS] | d_w[CYCLE_BITS] | d1_w[CYCLE_BITS]
			| ov_t | m_w[CYCLE_BITS] | w_w[CYCLE_BITS];

		// Register zero is never recorded, so it always reads as ready.
		sb_wr.en   = advance && (rd != '0)
			&& ((fmt == FMT_R) || (fmt == FMT_I) || (fmt == FMT_LOAD));
		sb_wr.addr = rd;
		sb_wr.data = (fmt == FMT_LOAD) ? m : e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_fetch_q <= '0;
			last_exec_q  <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				next_fetch_q <= d;
				last_exec_q  <= e;
				ovf_q        <= ovf_next;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fetch_cycle     <= next_fetch_q;
			decode_cycle    <= d;
			execute_cycle   <= e;
			memory_cycle    <= m;
			writeback_cycle <= w;
			decode_wait     <= d - f1;
			execute_wait    <= e - d1;
			format_class    <= 3'(fmt);
			overflow        <= ovf_next;
		end
	end

	assign out_valid = out_valid_q;

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		sb_wr.en |-> (sb_wr.addr != '0))
		else $error("scoreboard write to register zero");

	a_ex_after_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((execute_cycle > decode_cycle) || overflow))
		else $error("execute cycle not after decode cycle without saturation");

	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((memory_cycle >= execute_cycle) && (writeback_cycle >= memory_cycle)))
		else $error("memory or write back cycle out of order");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (ovf_q || !$past(ovf_q)))
		else $error("overflow flag cleared");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("pending item not moved into free output register");

endmodule

// ----- rtl/fpst_scoreboard.sv -----
// ----------------------------------------------------------------------------
// fpst_scoreboard
// Ready-cycle scoreboard: one synchronous memory with two read ports and one
// write port, per-entry valid bits, and forwarding of a same-edge write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpst_scoreboard import fpst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rd_en,
	input  reg_idx_t rs1,
	input  reg_idx_t rs2,
	input  sb_wr_t   wr,
	output cycle_t   r1,
	output cycle_t   r2
);

	cycle_t               mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;

	cycle_t rdata1_q;
	cycle_t rdata2_q;
	cycle_t fwd_data_q;
	logic   vld1_q;
	logic   vld2_q;
	logic   hit1_q;
	logic   hit2_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata1_q   <= mem[rs1];
			rdata2_q   <= mem[rs2];
			fwd_data_q <= wr.data;
		end
	end

	// A write on the same edge as the read is not seen by the memory read,
	// so it is caught here and forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld1_q <= 1'b0;
			vld2_q <= 1'b0;
			hit1_q <= 1'b0;
			hit2_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld1_q <= vld_q[rs1];
				vld2_q <= vld_q[rs2];
				hit1_q <= wr.en && (wr.addr == rs1);
				hit2_q <= wr.en && (wr.addr == rs2);
			end
		end
	end

	assign r1 = hit1_q ? fwd_data_q : (vld1_q ? rdata1_q : '0);
	assign r2 = hit2_q ? fwd_data_q : (vld2_q ? rdata2_q : '0);

endmodule
